[rtl/core/assert_macros.svh]
// Assertion macros shared by the rate meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define WER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle requires the consequent in the next cycle.
`define WER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/wer_pkg.sv]
// Shared types and constants of the windowed event rate meter.
`default_nettype none

package wer_pkg;

  localparam int SLOT_IN_W = 5;
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 30;
  localparam logic [RATE_W-1:0] RATE_MAX = 30'h3FFF_FFFF;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLEAR,
    ST_STEP,
    ST_BUMP_RD,
    ST_BUMP_WR,
    ST_SUM,
    ST_SUM_LAST,
    ST_DIV_INIT,
    ST_DIV,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic clear_wr;
    logic step_wr;
    logic bump_rd;
    logic bump_wr;
    logic sum_rd;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic slot_ok;
    logic need_clear;
    logic need_step;
    logic rate_zero;
    logic cur_last;
    logic step_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/wer_ctrl.sv]
// Controller state machine of the windowed event rate meter.
`default_nettype none
`include "assert_macros.svh"

module wer_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wer_pkg::sts_t      sts,
  output wer_pkg::ctl_t      ctl
);
  import wer_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.is_query) begin
          state_next = (!sts.slot_ok || sts.rate_zero) ? ST_DONE : ST_SUM;
        end else if (!sts.slot_ok) begin
          state_next = ST_IDLE;
        end else if (sts.need_clear) begin
          state_next = ST_CLEAR;
        end else if (sts.need_step) begin
          state_next = ST_STEP;
        end else begin
          state_next = ST_BUMP_RD;
        end
      end
      ST_CLEAR: begin
        if (sts.cur_last) state_next = ST_BUMP_RD;
      end
      ST_STEP: begin
        if (sts.step_last) state_next = ST_BUMP_RD;
      end
      ST_BUMP_RD:  state_next = ST_BUMP_WR;
      ST_BUMP_WR:  state_next = ST_IDLE;
      ST_SUM: begin
        if (sts.cur_last) state_next = ST_SUM_LAST;
      end
      ST_SUM_LAST: state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl          = '0;
    in_ready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_DECIDE:   ctl.prep     = 1'b1;
      ST_CLEAR:    ctl.clear_wr = 1'b1;
      ST_STEP:     ctl.step_wr  = 1'b1;
      ST_BUMP_RD:  ctl.bump_rd  = 1'b1;
      ST_BUMP_WR:  ctl.bump_wr  = 1'b1;
      ST_SUM:      ctl.sum_rd   = 1'b1;
      ST_SUM_LAST: ctl.sum_rd   = 1'b0;
      ST_DIV_INIT: ctl.div_init = 1'b1;
      ST_DIV:      ctl.div_step = 1'b1;
      ST_DONE:     ctl.out_load = sts.out_free;
      default:     ctl          = '0;
    endcase
  end

  `WER_ASSERT(a_div_only_query, (state != ST_DIV) || sts.is_query, "divider runs on a record")
  `WER_ASSERT(a_bump_only_record, (state != ST_BUMP_WR) || !sts.is_query, "bucket bump on a query")
  `WER_ASSERT_NEXT(a_clear_exit, state == ST_CLEAR, state == ST_CLEAR || state == ST_BUMP_RD, "clear sweep left early")

endmodule

`default_nettype wire

[rtl/core/wer_datapath.sv]
// Datapath of the windowed event rate meter: slot state, bucket memory, divider, result register.
`default_nettype none
`include "assert_macros.svh"

module wer_datapath #(
  parameter int NUM_SLOTS    = 32,
  parameter int NUM_BUCKETS  = 60,
  parameter int WINDOW_CAP   = 60,
  parameter int BUCKET_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_command,
  input  wire logic [wer_pkg::SLOT_IN_W-1:0] in_slot,
  input  wire logic [wer_pkg::TIME_W-1:0]    in_now,
  input  wer_pkg::ctl_t                      ctl,
  output wer_pkg::sts_t                      sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [wer_pkg::SLOT_IN_W-1:0]      out_slot,
  output logic                               out_has_data,
  output logic [wer_pkg::RATE_W-1:0]         out_rate,
  output logic [wer_pkg::TIME_W-1:0]         out_total,
  output logic [wer_pkg::TIME_W-1:0]         out_first,
  output logic [wer_pkg::TIME_W-1:0]         out_last
);
  import wer_pkg::*;

  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W     = $clog2(NUM_BUCKETS);
  localparam int MEM_DEPTH = NUM_SLOTS * NUM_BUCKETS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SUM_W     = BUCKET_WIDTH + $clog2(NUM_BUCKETS);
  localparam int DIVD_W    = SUM_W + 8;
  localparam int ACT_W     = $clog2(WINDOW_CAP + 1);
  localparam int DCNT_W    = $clog2(DIVD_W + 1);
  localparam int QX_W      = (DIVD_W > RATE_W) ? DIVD_W : RATE_W;

  // Latched item.
  logic                 cmd_q;
  logic [SLOT_IN_W-1:0] slot_q;
  logic [TIME_W-1:0]    now_q;

  // Per-slot state.
  logic [POS_W-1:0]  ring_pos  [NUM_SLOTS];
  logic [TIME_W-1:0] cur_sec   [NUM_SLOTS];
  logic [TIME_W-1:0] old_sec   [NUM_SLOTS];
  logic [TIME_W-1:0] tot       [NUM_SLOTS];
  logic [TIME_W-1:0] first_sec [NUM_SLOTS];
  logic [TIME_W-1:0] last_sec  [NUM_SLOTS];

  // Bucket memory.
  logic [BUCKET_WIDTH-1:0] mem [MEM_DEPTH];
  logic [BUCKET_WIDTH-1:0] rd_data;

  // Working registers.
  logic [POS_W-1:0]  cur;
  logic [POS_W-1:0]  steps_left;
  logic [SUM_W-1:0]  acc;
  logic              rd_pend;
  logic [ACT_W-1:0]  rem;
  logic [ACT_W-1:0]  divisor;
  logic [DIVD_W-1:0] quo;
  logic [DCNT_W-1:0] dcnt;

  logic [SLOT_W-1:0] sidx;
  logic              slot_ok;
  logic [TIME_W-1:0] s_cur, s_old, s_tot, s_first, s_last;
  logic [POS_W-1:0]  s_pos;
  logic [TIME_W:0]   dt, dold, dact;
  logic              dt_pos, dt_big, old_expire;
  logic              need_clear, need_step, rate_zero;
  logic [POS_W-1:0]  cur_wrap;
  logic [ADDR_W-1:0] base_addr, wr_addr, rd_addr;
  logic [POS_W-1:0]  wr_pos;
  logic              wr_en;
  logic [BUCKET_WIDTH-1:0] wr_data, bump_val;
  logic [ACT_W-1:0]  act;
  logic [ACT_W:0]    trial;
  logic              ge;
  logic [QX_W-1:0]   q_ext;
  logic [RATE_W-1:0] rate_sat;
  logic [TIME_W-1:0] old_base;

  // Slot state lookup and time differences.
  always_comb begin
    sidx       = SLOT_W'(slot_q);
    slot_ok    = 32'(slot_q) < 32'(NUM_SLOTS);
    s_pos      = ring_pos[sidx];
    s_cur      = cur_sec[sidx];
    s_old      = old_sec[sidx];
    s_tot      = tot[sidx];
    s_first    = first_sec[sidx];
    s_last     = last_sec[sidx];
    dt         = {1'b0, now_q} - {1'b0, s_cur};
    dold       = {1'b0, now_q} - {1'b0, s_old};
    dact       = {1'b0, s_cur} - {1'b0, s_old};
    dt_pos     = !dt[TIME_W] && (dt[TIME_W-1:0] != '0);
    dt_big     = !dt[TIME_W] && (dt[TIME_W-1:0] >= 32'(NUM_BUCKETS));
    old_expire = (s_old != '0) && !dold[TIME_W] && (dold[TIME_W-1:0] >= 32'(NUM_BUCKETS));
    need_clear = (s_cur == '0) || dt_big;
    need_step  = dt_pos && !need_clear;
    rate_zero  = (s_cur == '0) || (s_tot == '0) || dt_big || (s_old == '0);
    if (dact[TIME_W]) begin
      act = ACT_W'(1);
    end else if (dact[TIME_W-1:0] >= 32'(WINDOW_CAP)) begin
      act = ACT_W'(WINDOW_CAP);
    end else begin
      act = ACT_W'(dact[TIME_W-1:0] + 32'd1);
    end
    if (need_clear || (need_step && old_expire)) begin
      old_base = '0;
    end else begin
      old_base = s_old;
    end
  end

  // Memory addressing.
  always_comb begin
    cur_wrap  = (cur == POS_W'(NUM_BUCKETS - 1)) ? '0 : cur + 1'b1;
    base_addr = ADDR_W'(sidx) * ADDR_W'(NUM_BUCKETS);
    wr_pos    = ctl.step_wr ? cur_wrap : cur;
    wr_addr   = base_addr + ADDR_W'(wr_pos);
    rd_addr   = base_addr + ADDR_W'(cur);
    bump_val  = (&rd_data) ? rd_data : rd_data + 1'b1;
    wr_en     = ctl.clear_wr || ctl.step_wr || ctl.bump_wr;
    wr_data   = ctl.bump_wr ? bump_val : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.bump_rd || ctl.sum_rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Divider step and rate saturation.
  always_comb begin
    trial    = {rem, quo[DIVD_W-1]};
    ge       = trial >= {1'b0, divisor};
    q_ext    = QX_W'(quo);
    rate_sat = (q_ext > QX_W'(RATE_MAX)) ? RATE_MAX : q_ext[RATE_W-1:0];
  end

  // Item capture, ring cursor, sum and divider.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= in_command;
      slot_q <= in_slot;
      now_q  <= in_now;
    end
    if (ctl.prep) begin
      cur        <= (cmd_q == CMD_QUERY || need_clear) ? '0 : s_pos;
      steps_left <= POS_W'(dt[TIME_W-1:0]);
      acc        <= '0;
    end else if (ctl.clear_wr || ctl.sum_rd) begin
      cur <= cur_wrap;
    end else if (ctl.step_wr) begin
      cur        <= cur_wrap;
      steps_left <= steps_left - 1'b1;
    end
    if (rd_pend) begin
      acc <= acc + SUM_W'(rd_data);
    end
    if (ctl.div_init) begin
      rem     <= '0;
      quo     <= {acc, 8'b0};
      divisor <= act;
      dcnt    <= DCNT_W'(DIVD_W);
    end else if (ctl.div_step) begin
      rem  <= ge ? ACT_W'(trial - {1'b0, divisor}) : ACT_W'(trial);
      quo  <= {quo[DIVD_W-2:0], ge};
      dcnt <= dcnt - 1'b1;
    end
  end

  // Read-data valid flag for the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ctl.sum_rd;
    end
  end

  // Per-slot state update at the end of a record.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ring_pos[i]  <= '0;
        cur_sec[i]   <= '0;
        old_sec[i]   <= '0;
        tot[i]       <= '0;
        first_sec[i] <= '0;
        last_sec[i]  <= '0;
      end
    end else if (ctl.bump_wr && slot_ok) begin
      ring_pos[sidx] <= cur;
      if (need_clear || need_step) begin
        cur_sec[sidx] <= now_q;
      end
      old_sec[sidx]   <= (old_base == '0) ? now_q : old_base;
      tot[sidx]       <= (&s_tot) ? s_tot : s_tot + 1'b1;
      first_sec[sidx] <= (s_first == '0) ? now_q : s_first;
      last_sec[sidx]  <= now_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_slot <= slot_q;
      if (slot_ok) begin
        out_has_data <= s_tot != '0;
        out_rate     <= rate_zero ? '0 : rate_sat;
        out_total    <= s_tot;
        out_first    <= s_first;
        out_last     <= s_last;
      end else begin
        out_has_data <= 1'b0;
        out_rate     <= '0;
        out_total    <= '0;
        out_first    <= '0;
        out_last     <= '0;
      end
    end
  end

  // Status to the controller.
  always_comb begin
    sts            = '0;
    sts.is_query   = cmd_q == CMD_QUERY;
    sts.slot_ok    = slot_ok;
    sts.need_clear = need_clear;
    sts.need_step  = need_step;
    sts.rate_zero  = rate_zero;
    sts.cur_last   = cur == POS_W'(NUM_BUCKETS - 1);
    sts.step_last  = steps_left == POS_W'(1);
    sts.div_last   = dcnt == DCNT_W'(1);
    sts.out_free   = !out_valid || out_ready;
  end

  `WER_ASSERT(a_load_when_free, !ctl.out_load || !out_valid || out_ready, "result overwritten")
  `WER_ASSERT(a_rate_has_data, !out_valid || (out_rate == '0) || out_has_data, "rate without events")

endmodule

`default_nettype wire

[rtl/core/windowed_event_rate_meter.sv]
// Top level of the windowed event rate meter.
//
//  Channel | Dir | tdata fields (low bit up)                          | tuser
//  s_*     | in  | slot_index[4:0], now_sec[36:5], zero pad to 40      | command
//  m_*     | out | result_slot[4:0], rate_q8[34:5], total_events[66:35],| has_data
//          |     | first_seen_sec[98:67], last_seen_sec[130:99], pad 136|
//
// One item is handled at a time. In a record, the bucket sweep over one port of the
// bucket memory sets the long case. A query reads one bucket a cycle to sum its slot's
// window, then the divider makes one quotient bit a cycle; a query whose rate is zero
// or whose slot is out of range skips both.
// Reset clears all slot state at once; no memory clearing pass is needed because a
// slot's ring is swept clear on its first record.
// A result waits in the output register while the next item is taken in.
`default_nettype none

module windowed_event_rate_meter #(
  parameter int NUM_SLOTS    = 32,
  parameter int NUM_BUCKETS  = 60,
  parameter int WINDOW_CAP   = 60,
  parameter int BUCKET_WIDTH = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // slot_index, now_sec
  input  wire logic         s_tuser,   // command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // result_slot, rate_q8, total_events, first, last
  output logic              m_tuser    // has_data
);
  import wer_pkg::*;

  ctl_t ctl;
  sts_t sts;

  logic [SLOT_IN_W-1:0] out_slot;
  logic                 out_has_data;
  logic [RATE_W-1:0]    out_rate;
  logic [TIME_W-1:0]    out_total, out_first, out_last;

  wer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  wer_datapath #(
    .NUM_SLOTS    (NUM_SLOTS),
    .NUM_BUCKETS  (NUM_BUCKETS),
    .WINDOW_CAP   (WINDOW_CAP),
    .BUCKET_WIDTH (BUCKET_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_command   (s_tuser),
    .in_slot      (s_tdata[4:0]),
    .in_now       (s_tdata[36:5]),
    .ctl          (ctl),
    .sts          (sts),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_slot     (out_slot),
    .out_has_data (out_has_data),
    .out_rate     (out_rate),
    .out_total    (out_total),
    .out_first    (out_first),
    .out_last     (out_last)
  );

  // Pack the result beat.
  assign m_tdata = {5'b0, out_last, out_first, out_total, out_rate, out_slot};
  assign m_tuser = out_has_data;

endmodule

`default_nettype wire

[verif/rate_meter_checker.sv]
// Checker that predicts and compares the rate meter's query results.
`timescale 1ns / 100ps
`default_nettype none

module rate_meter_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [39:0]  s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [135:0] m_tdata,
  input  wire logic         m_tuser,
  output int                fail_count,
  output int                pending_answers
);
  import wer_pkg::*;

  localparam int SLOTS   = 32;
  localparam int BUCKETS = 60;
  localparam int CAP     = 60;
  localparam logic [15:0] BUCKET_TOP = 16'hFFFF;

  typedef struct packed {
    logic [31:0]       last_sec;
    logic [31:0]       first_sec;
    logic [31:0]       total;
    logic [RATE_W-1:0] rate;
    logic              has_data;
    logic [4:0]        slot;
  } answer_t;

  // Per-slot shadow state.
  logic [15:0] ring [SLOTS][BUCKETS];
  int unsigned pos [SLOTS];
  logic [31:0] cur_sec [SLOTS];
  logic [31:0] oldest_sec [SLOTS];
  logic [31:0] ev_total [SLOTS];
  logic [31:0] first_sec [SLOTS];
  logic [31:0] last_sec [SLOTS];

  answer_t expected_answers [$];

  assign pending_answers = expected_answers.size();

  function automatic longint sdiff(logic [31:0] a, logic [31:0] b);
    return longint'({32'b0, a}) - longint'({32'b0, b});
  endfunction

  task automatic wipe_ring(int s, logic [31:0] now);
    for (int i = 0; i < BUCKETS; i++) ring[s][i] = '0;
    pos[s] = 0;
    cur_sec[s] = now;
    oldest_sec[s] = '0;
  endtask

  task automatic record_event(int s, logic [31:0] now);
    longint d;
    d = sdiff(now, cur_sec[s]);
    // Bring the ring forward to this second.
    if (cur_sec[s] == 0 || d >= BUCKETS) begin
      wipe_ring(s, now);
    end else if (d > 0) begin
      for (longint i = 0; i < d; i++) begin
        pos[s] = (pos[s] + 1 >= BUCKETS) ? 0 : pos[s] + 1;
        ring[s][pos[s]] = '0;
      end
      cur_sec[s] = now;
      if (oldest_sec[s] != 0 && sdiff(now, oldest_sec[s]) >= BUCKETS) oldest_sec[s] = '0;
    end
    // Count the event.
    if (ring[s][pos[s]] != BUCKET_TOP) ring[s][pos[s]]++;
    if (oldest_sec[s] == 0) oldest_sec[s] = now;
    if (ev_total[s] != 32'hFFFF_FFFF) ev_total[s]++;
    if (first_sec[s] == 0) first_sec[s] = now;
    last_sec[s] = now;
  endtask

  function automatic logic [RATE_W-1:0] window_rate(int s, logic [31:0] now);
    longint unsigned sum;
    longint active;
    longint unsigned q;
    sum = 0;
    if (cur_sec[s] == 0 || ev_total[s] == 0) return '0;
    if (sdiff(now, cur_sec[s]) >= BUCKETS) return '0;
    if (oldest_sec[s] == 0) return '0;
    for (int i = 0; i < BUCKETS; i++) sum += ring[s][i];
    active = sdiff(cur_sec[s], oldest_sec[s]) + 1;
    if (active < 1) active = 1;
    if (active > CAP) active = CAP;
    q = (sum << 8) / longint'(active);
    return (q > RATE_MAX) ? RATE_MAX : q[RATE_W-1:0];
  endfunction

  // Predict on each accepted input beat and compare each output beat.
  always @(posedge clk) begin
    int s;
    logic [31:0] now;
    answer_t exp_a;
    answer_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        for (int j = 0; j < BUCKETS; j++) ring[i][j] = '0;
        pos[i] = 0;
        cur_sec[i] = '0;
        oldest_sec[i] = '0;
        ev_total[i] = '0;
        first_sec[i] = '0;
        last_sec[i] = '0;
      end
      expected_answers.delete();
      fail_count <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{last_sec: m_tdata[130:99], first_sec: m_tdata[98:67],
                total: m_tdata[66:35], rate: m_tdata[34:5], has_data: m_tuser,
                slot: m_tdata[4:0]};
        if (expected_answers.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            if (fail_count < 10)
              $display({"mismatch slot %0d: exp has=%0d rate=%h tot=%h first=%h last=%h",
                        " / got has=%0d rate=%h tot=%h first=%h last=%h"},
                exp_a.slot, exp_a.has_data, exp_a.rate, exp_a.total, exp_a.first_sec,
                exp_a.last_sec, got.has_data, got.rate, got.total, got.first_sec,
                got.last_sec);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        s = int'(s_tdata[4:0]);
        now = s_tdata[36:5];
        if (s_tuser == CMD_RECORD) begin
          record_event(s, now);
        end else begin
          exp_a.slot = s_tdata[4:0];
          exp_a.has_data = (ev_total[s] != 0);
          exp_a.rate = window_rate(s, now);
          exp_a.total = ev_total[s];
          exp_a.first_sec = first_sec[s];
          exp_a.last_sec = last_sec[s];
          expected_answers.push_back(exp_a);
        end
      end
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Top of the rate meter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import wer_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // slot_index, now_sec, zero pad
  logic         s_tuser;   // command
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;   // result_slot, rate_q8, total_events, first, last, pad
  logic         m_tuser;   // has_data
  int           fail_count;
  int           pending_answers;
  bit           steady;
  logic [31:0]  clock_sec;

  windowed_event_rate_meter i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rate_meter_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending_answers(pending_answers)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Receiver stalls at random except during the steady stretch.
  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 35);
  end

  // Send one beat, with a random gap before it outside the steady stretch; valid stays up for a back-to-back beat.
  task automatic send_beat(logic cmd, logic [4:0] slot, logic [31:0] now);
    while (!steady && $urandom_range(99) < 35) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b0, now, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random beat: mostly a slowly moving clock on few slots, some noise.
  task automatic random_beat();
    logic [4:0] slot;
    logic [31:0] now;
    slot = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
    case ($urandom_range(19))
      0: now = $urandom;
      1: now = clock_sec - $urandom_range(5);
      2: now = clock_sec + 32'($urandom_range(59, 130));
      default: now = clock_sec + $urandom_range(2);
    endcase
    clock_sec = now;
    if ($urandom_range(2) == 0) send_beat(CMD_QUERY, slot, now);
    else send_beat(CMD_RECORD, slot, now);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_RECORD;
    m_tready = 1'b0;
    steady = 1'b0;
    clock_sec = 32'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fresh slot, time zero, extremes, window gaps and wrap.
    send_beat(CMD_QUERY, 5'd0, 32'd5);
    send_beat(CMD_RECORD, 5'd1, 32'd0);
    send_beat(CMD_QUERY, 5'd1, 32'd0);
    send_beat(CMD_RECORD, 5'd31, 32'hFFFF_FFFF);
    send_beat(CMD_QUERY, 5'd31, 32'hFFFF_FFFF);
    send_beat(CMD_QUERY, 5'd31, 32'd3);
    send_beat(CMD_RECORD, 5'd2, 32'd100);
    send_beat(CMD_RECORD, 5'd2, 32'd100);
    send_beat(CMD_RECORD, 5'd2, 32'd130);
    send_beat(CMD_QUERY, 5'd2, 32'd130);
    send_beat(CMD_RECORD, 5'd2, 32'd159);
    send_beat(CMD_RECORD, 5'd2, 32'd160);
    send_beat(CMD_QUERY, 5'd2, 32'd160);
    send_beat(CMD_QUERY, 5'd2, 32'd219);
    send_beat(CMD_QUERY, 5'd2, 32'd220);
    send_beat(CMD_RECORD, 5'd2, 32'd150);
    send_beat(CMD_QUERY, 5'd2, 32'd100);
    send_beat(CMD_RECORD, 5'd2, 32'd500);
    send_beat(CMD_QUERY, 5'd2, 32'd500);
    send_beat(CMD_QUERY, 5'd21, 32'h5555_AAAA);
    s_tvalid <= 1'b0;

    // Wait for every answer before the random part.
    @(posedge clk);
    while (pending_answers != 0) @(posedge clk);

    // A burst with no idling on either side.
    steady = 1'b1;
    repeat (60) random_beat();
    steady = 1'b0;
    repeat (540) random_beat();
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_answers != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl/core
rtl/core/wer_pkg.sv
rtl/core/wer_ctrl.sv
rtl/core/wer_datapath.sv
rtl/core/windowed_event_rate_meter.sv
verif/rate_meter_checker.sv
verif/testbench.sv
